// ----- src/pllm_pkg.sv -----
package pllm_pkg;

    localparam int POOL_SLOTS = 16;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int DATA_W     = 32;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SLOTS);

    // operation codes
    localparam logic [3:0] ACT_ADD_FRONT   = 4'd0;
    localparam logic [3:0] ACT_ADD_BACK    = 4'd1;
    localparam logic [3:0] ACT_ADD_AFTER   = 4'd2;
    localparam logic [3:0] ACT_ADD_BEFORE  = 4'd3;
    localparam logic [3:0] ACT_REMOVE      = 4'd4;
    localparam logic [3:0] ACT_GET         = 4'd5;
    localparam logic [3:0] ACT_MOVE_BEFORE = 4'd6;
    localparam logic [3:0] ACT_MOVE_AFTER  = 4'd7;
    localparam logic [3:0] ACT_CLEAR       = 4'd8;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [3:0]        action;
        logic [SLOT_W-1:0] entry;
        logic [SLOT_W-1:0] moved_entry;
        logic [DATA_W-1:0] data_in;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] data_out;
        logic [LINK_W-1:0] next_slot;
        logic [LINK_W-1:0] prev_slot;
        logic [LINK_W-1:0] head_slot;
        logic [LINK_W-1:0] tail_slot;
        logic [LINK_W-1:0] count;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENT,
        S_MOV,
        S_WR1,
        S_WR2,
        S_WR3
    } t_state;

    // link rewrite plan for one operation
    typedef struct packed {
        logic              unlink;
        logic              link;
        logic              wr_data;
        logic [SLOT_W-1:0] s;
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        logic [LINK_W-1:0] pp;
        logic [LINK_W-1:0] nn;
    } t_plan;

endpackage

// ----- src/pllm_ram.sv -----
module pllm_ram
    import pllm_pkg::*;
#(
    parameter int WIDTH = DATA_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [POOL_SLOTS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pllm_free_search.sv -----
module pllm_free_search
    import pllm_pkg::*;
(
    input  logic [POOL_SLOTS-1:0] i_valid,
    input  logic [SLOT_W-1:0]     i_start,
    output logic [SLOT_W-1:0]     o_slot
);

    // first clear valid bit at or above start, wrapping round
    always_comb begin
        logic [SLOT_W-1:0] idx;
        o_slot = i_start;
        for (int k = POOL_SLOTS - 1; k >= 0; k--) begin
            idx = i_start + SLOT_W'(k);
            if (!i_valid[idx]) begin
                o_slot = idx;
            end
        end
    end

endmodule

// ----- src/pooled_linked_list_manager.sv -----
// doubly linked list kept in a fixed pool of slots
// input channel: i_in_valid / o_in_ready carry one operation word (t_in_word):
//   add front, add back, add after, add before, remove, get, move before,
//   move after or clear
// output channel: o_out_valid / i_out_ready carry one result word (t_out_word)
//   per operation: status, slot touched, its data and links, head, tail, count
// the item passes through states ENT, MOV, WR1, WR2 and WR3 before its result
//   is loaded; no new word is taken until then, as the sequencer does one
//   read of the anchor, one read of the moved slot and three write steps
//   through link and data memories with one write port each
// o_in_ready is high only while the sequencer is idle; the result sits in an
//   output register, so the block goes idle once the result is loaded
// receiver stall: the last write step holds until the output register is free
// reset: synchronous, active low; list empty, all slots invalid, no clearing
//   pass needed since slot valid bits live in flip-flops and mask the memories
module pooled_linked_list_manager
    import pllm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_state r_state, n_state;

    // list state
    logic [POOL_SLOTS-1:0] r_valid, n_valid;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [LINK_W-1:0]     r_tail, n_tail;
    logic [LINK_W-1:0]     r_len, n_len;
    logic [SLOT_W-1:0]     r_ss, n_ss;

    // item in progress
    t_in_word          r_item;
    logic [LINK_W-1:0] r_ent_next, r_ent_prev;
    logic [DATA_W-1:0] r_ent_data;
    t_plan             r_plan, n_plan;
    t_out_word         r_res, n_res;

    // output register
    t_out_word r_out_word;
    logic      r_out_valid;
    logic      out_load;

    // memory ports
    logic              next_we, prev_we, data_we;
    logic [SLOT_W-1:0] next_waddr, prev_waddr, data_waddr, raddr;
    logic [LINK_W-1:0] next_wdata, prev_wdata, next_rd, prev_rd;
    logic [DATA_W-1:0] data_rd;
    logic [SLOT_W-1:0] free_slot;

    pllm_ram #(.WIDTH(LINK_W)) u_next_mem (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (raddr),
        .o_rdata (next_rd)
    );

    pllm_ram #(.WIDTH(LINK_W)) u_prev_mem (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (raddr),
        .o_rdata (prev_rd)
    );

    pllm_ram #(.WIDTH(DATA_W)) u_data_mem (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (r_item.data_in),
        .i_raddr (raddr),
        .o_rdata (data_rd)
    );

    pllm_free_search u_free (
        .i_valid (r_valid),
        .i_start (r_ss),
        .o_slot  (free_slot)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_load    = (r_state == S_WR3) && (!r_out_valid || i_out_ready);

    // anchor is read on acceptance, the moved slot in the following cycle
    assign raddr = (r_state == S_IDLE) ? i_in_word.entry : r_item.moved_entry;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ENT;
            S_ENT:  n_state = S_MOV;
            S_MOV:  n_state = S_WR1;
            S_WR1:  n_state = S_WR2;
            S_WR2:  n_state = S_WR3;
            S_WR3:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // capture item and anchor read; unwritten or freed slots read as no link
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_word;
        end
        if (r_state == S_ENT) begin
            r_ent_next <= r_valid[r_item.entry] ? next_rd : LINK_NONE;
            r_ent_prev <= r_valid[r_item.entry] ? prev_rd : LINK_NONE;
            r_ent_data <= data_rd;
        end
        if (r_state == S_MOV) begin
            r_plan <= n_plan;
            r_res  <= n_res;
        end
    end

    // decode and plan, in the cycle the moved slot's links arrive
    always_comb begin
        logic              ent_live, mov_live, show;
        logic [LINK_W-1:0] mov_next, mov_prev, h1, t1;
        logic [DATA_W-1:0] show_data;
        logic [LINK_W-1:0] show_next, show_prev;

        ent_live  = r_valid[r_item.entry];
        mov_live  = r_valid[r_item.moved_entry];
        mov_next  = mov_live ? next_rd : LINK_NONE;
        mov_prev  = mov_live ? prev_rd : LINK_NONE;
        show      = 1'b0;
        show_data = '0;
        show_next = LINK_NONE;
        show_prev = LINK_NONE;

        n_plan    = '0;
        n_plan.p  = LINK_NONE;
        n_plan.n  = LINK_NONE;
        n_plan.pp = LINK_NONE;
        n_plan.nn = LINK_NONE;
        n_valid   = r_valid;
        n_len     = r_len;
        n_ss      = r_ss;
        n_res        = '0;
        n_res.status = STAT_OK;

        case (r_item.action)
            ACT_ADD_FRONT, ACT_ADD_BACK, ACT_ADD_AFTER, ACT_ADD_BEFORE: begin
                if ((r_item.action == ACT_ADD_AFTER || r_item.action == ACT_ADD_BEFORE)
                    && !ent_live) begin
                    n_res.status = STAT_BAD;
                    n_res.slot   = r_item.entry;
                end else if (r_len == LINK_W'(POOL_SLOTS)) begin
                    n_res.status = STAT_FULL;
                end else begin
                    n_plan.link    = 1'b1;
                    n_plan.wr_data = 1'b1;
                    n_plan.s       = free_slot;
                    case (r_item.action)
                        ACT_ADD_FRONT: begin
                            n_plan.nn = r_head;
                        end
                        ACT_ADD_BACK: begin
                            n_plan.pp = r_tail;
                        end
                        ACT_ADD_AFTER: begin
                            n_plan.pp = {1'b0, r_item.entry};
                            n_plan.nn = r_ent_next;
                        end
                        default: begin
                            n_plan.pp = r_ent_prev;
                            n_plan.nn = {1'b0, r_item.entry};
                        end
                    endcase
                    n_valid[free_slot] = 1'b1;
                    n_len      = r_len + 1'b1;
                    n_ss       = free_slot;
                    n_res.slot = free_slot;
                    show       = 1'b1;
                    show_data  = r_item.data_in;
                end
            end
            ACT_REMOVE: begin
                n_res.slot = r_item.entry;
                if (!ent_live) begin
                    n_res.status = STAT_BAD;
                end else begin
                    n_plan.unlink = 1'b1;
                    n_plan.p      = r_ent_prev;
                    n_plan.n      = r_ent_next;
                    n_valid[r_item.entry] = 1'b0;
                    n_len = r_len - 1'b1;
                end
            end
            ACT_GET: begin
                n_res.slot = r_item.entry;
                if (!ent_live) begin
                    n_res.status = STAT_BAD;
                end else begin
                    show      = 1'b1;
                    show_data = r_ent_data;
                end
            end
            ACT_MOVE_BEFORE, ACT_MOVE_AFTER: begin
                if (!ent_live || !mov_live || r_item.entry == r_item.moved_entry) begin
                    n_res.status = STAT_BAD;
                    n_res.slot   = ent_live ? r_item.moved_entry : r_item.entry;
                end else begin
                    n_plan.unlink = 1'b1;
                    n_plan.link   = 1'b1;
                    n_plan.s      = r_item.moved_entry;
                    n_plan.p      = mov_prev;
                    n_plan.n      = mov_next;
                    // anchor links as they stand after the moved slot is unlinked
                    if (r_item.action == ACT_MOVE_BEFORE) begin
                        n_plan.pp = (mov_next == {1'b0, r_item.entry}) ? mov_prev
                                                                     : r_ent_prev;
                        n_plan.nn = {1'b0, r_item.entry};
                    end else begin
                        n_plan.pp = {1'b0, r_item.entry};
                        n_plan.nn = (mov_prev == {1'b0, r_item.entry}) ? mov_next
                                                                     : r_ent_next;
                    end
                    n_res.slot = r_item.moved_entry;
                    show       = 1'b1;
                    show_data  = data_rd;
                end
            end
            ACT_CLEAR: begin
                n_valid = '0;
                n_len   = '0;
                n_ss    = '0;
            end
            default: begin
            end
        endcase

        // head and tail: unlink first, then link
        h1 = (n_plan.unlink && n_plan.p == LINK_NONE) ? n_plan.n : r_head;
        t1 = (n_plan.unlink && n_plan.n == LINK_NONE) ? n_plan.p : r_tail;
        n_head = (n_plan.link && n_plan.pp == LINK_NONE) ? {1'b0, n_plan.s} : h1;
        n_tail = (n_plan.link && n_plan.nn == LINK_NONE) ? {1'b0, n_plan.s} : t1;
        if (r_item.action == ACT_CLEAR) begin
            n_head = LINK_NONE;
            n_tail = LINK_NONE;
        end

        if (show) begin
            show_next = n_plan.link ? n_plan.nn : r_ent_next;
            show_prev = n_plan.link ? n_plan.pp : r_ent_prev;
        end
        n_res.data_out  = show_data;
        n_res.next_slot = show_next;
        n_res.prev_slot = show_prev;
        n_res.head_slot = n_head;
        n_res.tail_slot = n_tail;
        n_res.count     = n_len;
    end

    // list state commits once the plan is made
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= LINK_NONE;
            r_tail  <= LINK_NONE;
            r_len   <= '0;
            r_ss    <= '0;
        end else if (r_state == S_MOV) begin
            r_valid <= n_valid;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_len   <= n_len;
            r_ss    <= n_ss;
        end
    end

    // link rewrite steps in list order: unlink, slot links, neighbor links
    always_comb begin
        next_we    = 1'b0;
        prev_we    = 1'b0;
        data_we    = 1'b0;
        next_waddr = r_plan.s;
        prev_waddr = r_plan.s;
        data_waddr = r_plan.s;
        next_wdata = r_plan.nn;
        prev_wdata = r_plan.pp;
        case (r_state)
            S_WR1: begin
                prev_we    = r_plan.unlink && (r_plan.n != LINK_NONE);
                prev_waddr = r_plan.n[SLOT_W-1:0];
                prev_wdata = r_plan.p;
                next_we    = r_plan.unlink && (r_plan.p != LINK_NONE);
                next_waddr = r_plan.p[SLOT_W-1:0];
                next_wdata = r_plan.n;
            end
            S_WR2: begin
                prev_we = r_plan.link;
                next_we = r_plan.link;
                data_we = r_plan.wr_data;
            end
            S_WR3: begin
                // repeats harmlessly while the output is stalled
                next_we    = r_plan.link && (r_plan.pp != LINK_NONE);
                next_waddr = r_plan.pp[SLOT_W-1:0];
                next_wdata = {1'b0, r_plan.s};
                prev_we    = r_plan.link && (r_plan.nn != LINK_NONE);
                prev_waddr = r_plan.nn[SLOT_W-1:0];
                prev_wdata = {1'b0, r_plan.s};
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= r_res;
        end
    end

    // live slot count tracks the length
    a_len_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_len))
        else $error("length differs from number of live slots");

    // empty list has no head and no tail
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_head == LINK_NONE) == (r_len == '0)) && ((r_tail == LINK_NONE) == (r_len == '0)))
        else $error("head or tail disagrees with length");

    // no memory write while idle and accepting
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(next_we || prev_we || data_we))
        else $error("memory write while idle");

endmodule
